[hw/rtl/rcfcf_pkg.sv]
// shared types and constants for the rc frame change filter
package rcfcf_pkg;

    localparam int FRAME_LEN = 7;
    localparam int HELD_LEN = FRAME_LEN - 1;
    localparam int NUM_CH = 4;
    localparam int FILL_W = $clog2(HELD_LEN + 1);
    localparam int SEL_W = $clog2(NUM_CH);

    localparam logic [5:0] CODE_BASE = 6'd32;

    localparam logic [7:0] BEGIN_MARKER_RST = 8'd91;
    localparam logic [7:0] END_MARKER_RST = 8'd93;
    localparam logic [7:0] CONTROL_TYPE_RST = 8'd33;

    localparam logic [1:0] REG_BEGIN_MARKER = 2'd0;
    localparam logic [1:0] REG_END_MARKER = 2'd1;
    localparam logic [1:0] REG_CONTROL_TYPE = 2'd2;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        byte_t begin_marker;
        byte_t end_marker;
        byte_t control_type;
    } cfg_t;

    typedef struct packed {
        logic hit;
        logic [NUM_CH-1:0][7:0] value;
    } cand_t;

endpackage

[hw/rtl/rcfcf_parse.sv]
// input register, byte window and control frame detection
module rcfcf_parse (
    input  logic            clk,
    input  logic            rst_n,
    input  rcfcf_pkg::cfg_t cfg,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,
    input  logic            stall,
    output rcfcf_pkg::cand_t cand
);
    import rcfcf_pkg::*;

    logic                  in_valid_reg;
    byte_t                 in_byte_reg;
    byte_t                 win_reg [HELD_LEN];
    byte_t                 win_next [HELD_LEN];
    logic [FILL_W-1:0]     fill_reg;
    logic [FILL_W-1:0]     fill_next;
    logic                  proc_fire;
    logic                  full;
    logic                  frame;

    assign proc_fire = in_valid_reg && !stall;
    assign s_tready = !in_valid_reg || proc_fire;
    assign full = (fill_reg == FILL_W'(HELD_LEN));
    assign frame = (win_reg[0] == cfg.begin_marker) && (in_byte_reg == cfg.end_marker);

    always_comb
    begin
        cand.hit = in_valid_reg && full && frame && (win_reg[1] == cfg.control_type);
        for (int i = 0; i < NUM_CH; i++)
        begin
            cand.value[i] = win_reg[2 + i];
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        for (int i = 0; i < HELD_LEN; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (proc_fire)
        begin
            if (!full)
            begin
                for (int i = 0; i < HELD_LEN; i++)
                begin
                    if (fill_reg == FILL_W'(i))
                    begin
                        win_next[i] = in_byte_reg;
                    end
                end
                fill_next = fill_reg + FILL_W'(1);
            end
            else if (frame)
            begin
                fill_next = '0;
            end
            else
            begin
                for (int i = 0; i < HELD_LEN - 1; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[HELD_LEN - 1] = in_byte_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            fill_reg <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
        for (int i = 0; i < HELD_LEN; i++)
        begin
            win_reg[i] <= win_next[i];
        end
    end

endmodule

[hw/rtl/rcfcf_emit.sv]
// per-channel change compare, result buffer and output serializer
module rcfcf_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  rcfcf_pkg::cand_t cand,
    output logic             stall,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [5:0]       channel_code,
    output logic [7:0]       channel_value,
    output logic             last_of_run
);
    import rcfcf_pkg::*;

    logic [NUM_CH-1:0]      sent_reg;
    byte_t                  last_val_reg [NUM_CH];
    logic [NUM_CH-1:0]      mask_reg;
    logic [NUM_CH-1:0]      mask_next;
    byte_t                  res_val_reg [NUM_CH];
    logic [NUM_CH-1:0]      changes;
    logic [SEL_W-1:0]       sel;
    logic [NUM_CH-1:0]      sel_oh;
    logic                   take;
    logic                   buf_free;
    logic                   fire;
    logic                   load;

    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            changes[i] = !sent_reg[i] || (last_val_reg[i] != cand.value[i]);
        end
    end

    // lowest pending channel goes first
    always_comb
    begin
        sel = '0;
        for (int i = NUM_CH - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel = SEL_W'(i);
            end
        end
    end

    assign sel_oh = NUM_CH'(1) << sel;
    assign m_tvalid = |mask_reg;
    assign take = m_tvalid && m_tready;
    assign last_of_run = ((mask_reg & ~sel_oh) == '0);
    assign channel_code = CODE_BASE + 6'(sel);
    assign channel_value = res_val_reg[sel];

    assign buf_free = (mask_reg == '0) || (take && last_of_run);
    assign stall = cand.hit && (|changes) && !buf_free;
    assign fire = cand.hit && !stall;
    assign load = fire && (|changes);

    always_comb
    begin
        mask_next = mask_reg;
        if (load)
        begin
            mask_next = changes;
        end
        else if (take)
        begin
            mask_next = mask_reg & ~sel_oh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            sent_reg <= '0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                last_val_reg[i] <= '0;
            end
        end
        else
        begin
            mask_reg <= mask_next;
            if (fire)
            begin
                sent_reg <= '1;
                for (int i = 0; i < NUM_CH; i++)
                begin
                    last_val_reg[i] <= cand.value[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                res_val_reg[i] <= cand.value[i];
            end
        end
    end

endmodule

[hw/rtl/rc_frame_change_filter_unit.sv]
// top level of the rc frame change filter
//
// takes a received command byte stream on the s_ side, one byte per item,
// and searches it for seven-byte frames: begin marker, type byte, throttle,
// yaw, pitch, roll, end marker. a matched frame is consumed whole; any other
// byte slides the window by one. for a control frame, every channel whose
// value differs from the last one sent (or was never sent) gives one item on
// the m_ side, in channel order, with tlast on the final item of the frame.
// a byte is taken every cycle unless stalled; the first result is offered after the
// closing byte passes the input register and the result buffer, and results leave
// one per cycle while m_tready is high. the four-entry result buffer is the only
// point of contention: a frame with changes waits in the input register (s_tready
// low only then) while earlier results drain; a stalled m_ side holds its item stable.
// reset restores the default markers, empties the window and forgets all
// sent values, so the first control frame emits all four channels.
// cfg_we writes cfg_wdata to register cfg_addr: 0 begin marker,
// 1 end marker, 2 control type; other indexes are ignored.
module rc_frame_change_filter_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_addr,
    input  logic [7:0] cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [15:0] m_tdata,  // channel_code [5:0], channel_value [13:6], zero pad
    output logic       m_tlast
);
    import rcfcf_pkg::*;

    cfg_t       cfg_reg;
    cand_t      cand;
    logic       stall;
    logic [5:0] channel_code;
    logic [7:0] channel_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.begin_marker <= BEGIN_MARKER_RST;
            cfg_reg.end_marker <= END_MARKER_RST;
            cfg_reg.control_type <= CONTROL_TYPE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_BEGIN_MARKER: cfg_reg.begin_marker <= cfg_wdata;
                REG_END_MARKER:   cfg_reg.end_marker <= cfg_wdata;
                REG_CONTROL_TYPE: cfg_reg.control_type <= cfg_wdata;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    rcfcf_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .stall    (stall),
        .cand     (cand)
    );

    rcfcf_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .cand          (cand),
        .stall         (stall),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .channel_code  (channel_code),
        .channel_value (channel_value),
        .last_of_run   (m_tlast)
    );

    assign m_tdata = {2'b00, channel_value, channel_code};

endmodule
